FILE: rtl/prfc_pkg.sv
// Shared types, constants and status codes for the PLL ratio calculator.
package prfc_pkg;

  localparam int RATE_BITS = 32;
  localparam int PROD_BITS = 2 * RATE_BITS;
  localparam int NUM_BITS = RATE_BITS + 20;
  localparam int HIRES_SHIFT = 20;
  localparam int HIMULT_SHIFT = 12;
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = 2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_STATIC_BIG = 3'd1,
    ST_TOO_HIGH   = 3'd2,
    ST_INEXACT    = 3'd3,
    ST_ZERO       = 3'd4,
    ST_P_ZERO     = 3'd5
  } status_t;

  // Request classified by the front part, waiting for the back part
  typedef struct packed {
    logic [1:0]           slot;
    logic [RATE_BITS-1:0] p;
    logic [RATE_BITS-1:0] q;
    logic [RATE_BITS-1:0] rate;
    logic                 dyn;
  } req_t;

  // Result item
  typedef struct packed {
    logic [1:0]  slot;
    logic [31:0] word;
    logic        fmt;
    logic        wcfg;
    logic        trunc;
    status_t     status;
  } res_t;

endpackage

FILE: rtl/prfc_div.sv
// Pipelined restoring divider: one quotient bit per stage, one request per cycle while adv is high.
module prfc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  logic                                 adv,
  input  logic [prfc_pkg::NUM_BITS-1:0]        in_num,
  input  logic [prfc_pkg::RATE_BITS-1:0]       in_den,
  input  prfc_pkg::req_t                       in_tag,
  output logic                                 out_vld,
  output logic [prfc_pkg::NUM_BITS-1:0]        out_quo,
  output logic [prfc_pkg::RATE_BITS-1:0]       out_rem,
  output prfc_pkg::req_t                       out_tag
);
  localparam int N = prfc_pkg::NUM_BITS;
  localparam int W = prfc_pkg::RATE_BITS;

  logic           vld_r [N+1];
  logic [N-1:0]   num_r [N+1];
  logic [W:0]     rem_r [N+1];
  logic [W-1:0]   den_r [N+1];
  prfc_pkg::req_t tag_r [N+1];

  // Stage zero captures the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
    if (adv) begin
      num_r[0] <= in_num;
      rem_r[0] <= '0;
      den_r[0] <= in_den;
      tag_r[0] <= in_tag;
    end
  end

  // Each stage shifts in one numerator bit and tries a subtract
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [W+1:0] trial;
    logic [W:0]   rem_nxt;
    assign trial = {rem_r[i], num_r[i][N-1]};
    always_comb begin
      if (trial >= {2'b00, den_r[i]}) begin
        rem_nxt = (W+1)'(trial - {2'b00, den_r[i]});
      end else begin
        rem_nxt = trial[W:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (adv) begin
        num_r[i+1] <= {num_r[i][N-2:0], (trial >= {2'b00, den_r[i]})};
        rem_r[i+1] <= rem_nxt;
        den_r[i+1] <= den_r[i];
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_quo = num_r[N];
  assign out_rem = rem_r[N][W-1:0];
  assign out_tag = tag_r[N];
endmodule

FILE: rtl/prfc_front.sv
// Front part: forms the plain ratio out*q/p and classifies the request.
module prfc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  output logic                                 in_rdy,
  input  prfc_pkg::req_t                       in_req,
  output logic                                 q_vld,
  input  logic                                 q_rdy,
  output prfc_pkg::req_t                       q_req,
  output logic                                 q_hires,
  output logic                                 q_skip,
  output prfc_pkg::status_t                    q_status
);
  localparam int W = prfc_pkg::RATE_BITS;
  localparam int P = prfc_pkg::PROD_BITS;

  logic           adv;
  logic           m_vld_r;
  logic [P-1:0]   prod_r;
  prfc_pkg::req_t m_req_r;
  logic [P-1:0]   num_in;
  logic [P-1:0]   quo;

  // The pipe moves whenever its last slot is free
  assign adv    = !q_vld || q_rdy;
  assign in_rdy = adv;

  // Multiply rate by q (registered before the divider)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= in_vld;
    end
    if (adv) begin
      prod_r  <= P'(in_req.rate) * P'(in_req.q);
      m_req_r <= in_req;
    end
  end

  // Divide the low 52 bits of the product by p, upper bits only matter above 2^20
  logic [prfc_pkg::NUM_BITS-1:0] dq;
  logic [W-1:0]                  drem;
  prfc_pkg::req_t                dtag;
  logic                          dvld;

  // Product bits above the divider width mean a plain ratio of at least 2^20
  assign num_in = prod_r;

  prfc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (m_vld_r),
    .adv     (adv),
    .in_num  (num_in[prfc_pkg::NUM_BITS-1:0] >> 0),
    .in_den  (m_req_r.p),
    .in_tag  (m_req_r),
    .out_vld (dvld),
    .out_quo (dq),
    .out_rem (drem),
    .out_tag (dtag)
  );

  // Carry the overflow flag alongside the divider
  logic big_d_r [prfc_pkg::NUM_BITS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      big_d_r[0] <= (num_in[P-1:prfc_pkg::NUM_BITS] != '0);
      for (int i = 0; i < prfc_pkg::NUM_BITS; i++) big_d_r[i+1] <= big_d_r[i];
    end
  end

  // Classify
  logic hires, huge;
  assign quo   = {12'd0, dq};
  assign huge  = big_d_r[prfc_pkg::NUM_BITS] || (quo >= P'(1 << 20));
  assign hires = !big_d_r[prfc_pkg::NUM_BITS] && (quo < P'(1 << 12));

  always_comb begin
    q_vld    = dvld;
    q_req    = dtag;
    q_hires  = hires;
    q_skip   = 1'b1;
    q_status = prfc_pkg::ST_OK;
    if (dtag.p == '0) begin
      q_status = prfc_pkg::ST_P_ZERO;
    end else if (!hires && !dtag.dyn) begin
      q_status = prfc_pkg::ST_STATIC_BIG;
    end else if (!hires && huge) begin
      q_status = prfc_pkg::ST_TOO_HIGH;
    end else begin
      q_skip = 1'b0;
    end
  end
  logic unused;
  assign unused = ^drem;
endmodule

FILE: rtl/prfc_back.sv
// Back part: fixed-point divide, exactness and zero checks, scaling by q.
module prfc_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  output logic                                 in_rdy,
  input  prfc_pkg::req_t                       in_req,
  input  logic                                 in_hires,
  input  logic                                 in_skip,
  input  prfc_pkg::status_t                    in_status,
  output logic                                 out_vld,
  input  logic                                 out_rdy,
  output prfc_pkg::res_t                       out_res
);
  localparam int W = prfc_pkg::RATE_BITS;
  localparam int N = prfc_pkg::NUM_BITS;

  typedef struct packed {
    logic              hires;
    logic              skip;
    prfc_pkg::status_t status;
  } ctl_t;

  logic adv;
  logic [N-1:0] num;
  ctl_t ctl_in, dctl;
  logic [N-1:0] dq;
  logic [W-1:0] drem;
  logic         dvld;
  prfc_pkg::req_t dtag;

  assign adv    = !out_vld || out_rdy;
  assign in_rdy = adv;

  // Scale the output rate into the chosen format
  assign num = in_hires ? (N'(in_req.rate) << prfc_pkg::HIRES_SHIFT)
                        : (N'(in_req.rate) << prfc_pkg::HIMULT_SHIFT);
  assign ctl_in = '{hires: in_hires, skip: in_skip, status: in_status};

  prfc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .adv     (adv),
    .in_num  (num),
    .in_den  ((in_req.p == '0) ? W'(1) : in_req.p),
    .in_tag  (in_req),
    .out_vld (dvld),
    .out_quo (dq),
    .out_rem (drem),
    .out_tag (dtag)
  );

  // Carry control alongside the divider
  ctl_t ctl_r [N+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_in;
      for (int i = 0; i < N; i++) ctl_r[i+1] <= ctl_r[i];
    end
  end
  assign dctl = ctl_r[N];

  // Decide the status of the request leaving the divider
  prfc_pkg::status_t st_nxt;
  logic              err_nxt;
  always_comb begin
    err_nxt = 1'b1;
    st_nxt  = dctl.status;
    if (!dctl.skip) begin
      if (dtag.dyn && drem != '0) begin
        st_nxt = prfc_pkg::ST_INEXACT;
      end else if (dctl.hires && (dq == '0 || dtag.q == '0)) begin
        st_nxt = prfc_pkg::ST_ZERO;
      end else begin
        st_nxt  = prfc_pkg::ST_OK;
        err_nxt = 1'b0;
      end
    end
  end

  // Register status and multiply quotient by q (quotient fits 52 bits: two partials)
  ctl_t          m_ctl_r;
  prfc_pkg::req_t m_req_r;
  logic          m_vld_r, m_err_r;
  prfc_pkg::status_t m_st_r;
  logic [63:0]   plo_r, phi_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= dvld;
    end
    if (adv) begin
      m_ctl_r <= dctl;
      m_req_r <= dtag;
      plo_r   <= 64'(dq[31:0]) * 64'(dtag.q);
      phi_r   <= 64'(dq[N-1:32]) * 64'(dtag.q);
      m_err_r <= err_nxt;
      m_st_r  <= st_nxt;
    end
  end

  // Combine partials and register the result
  logic [95:0] full;
  assign full = {32'd0, plo_r} + {phi_r, 32'd0};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= m_vld_r;
    end
    if (adv) begin
      out_res.slot   <= m_req_r.slot;
      out_res.status <= m_st_r;
      out_res.word   <= m_err_r ? 32'd0 : full[31:0];
      out_res.fmt    <= !m_err_r && m_ctl_r.hires;
      out_res.wcfg   <= !m_err_r && m_req_r.dyn;
      out_res.trunc  <= !m_err_r && (full[95:32] != '0);
    end
  end
endmodule

FILE: rtl/pll_ratio_fixed_point_calc.sv
// Top level: PLL ratio fixed-point calculator.
// Throughput one request per cycle while neither part freezes; the front divider (plain ratio) and back divider
// (fixed-point quotient) are 52-stage pipelines, one quotient bit per stage.
// A four-entry queue parts them: the front freezes only while the queue is full,
// the back freezes while a result waits on out_tready.
// Reset (rst_n low, synchronous) clears all valid flags and the queue; no clearing pass.
module pll_ratio_fixed_point_calc (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] ratio_slot, [33:2] in_rate_num, [65:34] in_rate_den,
  // [97:66] target_rate, [98] dynamic_mode, [103:99] zero
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] slot_out, [33:2] ratio_word, [34] ratio_format,
  // [35] write_format_cfg, [36] ratio_truncated, [39:37] status
  output logic [39:0]  out_tdata
);
  typedef struct packed {
    prfc_pkg::req_t    req;
    logic              hires;
    logic              skip;
    prfc_pkg::status_t status;
  } qent_t;

  prfc_pkg::req_t    req, q_req;
  logic              q_vld, q_rdy, q_hires, q_skip;
  prfc_pkg::status_t q_status;
  prfc_pkg::res_t    res;

  qent_t                          qmem [prfc_pkg::QDEPTH];
  qent_t                          head;
  logic [prfc_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [prfc_pkg::QPTR_BITS:0]   count_r, count_nxt;
  logic                           q_push, q_pop, b_vld, b_rdy;

  assign req = '{slot: in_tdata[1:0], p: in_tdata[33:2], q: in_tdata[65:34],
                 rate: in_tdata[97:66], dyn: in_tdata[98]};

  prfc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(in_tvalid), .in_rdy(in_tready), .in_req(req),
    .q_vld(q_vld), .q_rdy(q_rdy), .q_req(q_req), .q_hires(q_hires),
    .q_skip(q_skip), .q_status(q_status)
  );

  // Queue between the parts: accept while not full, offer while not empty
  assign q_rdy  = (count_r != (prfc_pkg::QPTR_BITS+1)'(prfc_pkg::QDEPTH));
  assign b_vld  = (count_r != '0);
  assign q_push = q_vld && q_rdy;
  assign q_pop  = b_vld && b_rdy;
  assign head   = qmem[rd_ptr_r];

  always_comb begin
    case ({q_push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Advance the pointers and store the pushed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (q_push) begin
      qmem[wr_ptr_r] <= '{req: q_req, hires: q_hires, skip: q_skip, status: q_status};
    end
  end

  prfc_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(b_vld), .in_rdy(b_rdy), .in_req(head.req),
    .in_hires(head.hires), .in_skip(head.skip), .in_status(head.status),
    .out_vld(out_tvalid), .out_rdy(out_tready), .out_res(res)
  );

  assign out_tdata = {res.status, res.trunc, res.wcfg, res.fmt, res.word, res.slot};
endmodule
